// ===== hw/rtl/bprm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprm_pkg
// shared constants, item kinds and scan event type for the button pulse
// report manager
// ----------------------------------------------------------------------------
package bprm_pkg;

    localparam int NUM_BUTTONS = 32;
    localparam int TICK_BITS   = 32;
    localparam int SLOT_COUNT  = 32;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);

    localparam int BTN_W   = 32;
    localparam int KIND_W  = 2;
    localparam int DUR_W   = 31;

    localparam int S_FIELD_W = BTN_W + SLOT_W + DUR_W + 1;
    localparam int S_DATA_W  = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W  = BTN_W;

    localparam logic [BTN_W-1:0] BTN_MASK =
        BTN_W'((64'd1 << NUM_BUTTONS) - 64'd1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_BUTTONS - 1);

    localparam logic [KIND_W-1:0] KIND_SET    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PULSE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REFUSE = 2'd3;

    typedef struct packed {
        logic              due;
        logic              done;
        logic [SLOT_W-1:0] idx;
    } scan_evt_t;

endpackage

// ===== hw/rtl/bprm_expire_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprm_expire_scan
// release time memory and the shared wrap-safe due compare, stepped over
// all buttons one entry per cycle
// ----------------------------------------------------------------------------
module bprm_expire_scan (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [bprm_pkg::SLOT_W-1:0]       wr_idx,
    input  logic [bprm_pkg::TICK_BITS-1:0]    wr_data,
    input  logic                              start,
    input  logic [bprm_pkg::TICK_BITS-1:0]    now_ticks,
    output bprm_pkg::scan_evt_t               evt
);
    import bprm_pkg::*;

    logic [TICK_BITS-1:0] release_mem [SLOT_COUNT];

    logic                 issue_reg, issue_next;
    logic [SLOT_W-1:0]    addr_reg, addr_next;
    logic                 rd_vld_reg;
    logic [SLOT_W-1:0]    rd_idx_reg;
    logic [TICK_BITS-1:0] rd_data_reg;
    logic [TICK_BITS-1:0] diff;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            release_mem[wr_idx] <= wr_data;
        end
        if (issue_reg) begin
            rd_data_reg <= release_mem[addr_reg];
        end
        rd_idx_reg <= addr_reg;
    end

    always_comb begin
        issue_next = issue_reg;
        addr_next  = addr_reg;
        if (start) begin
            issue_next = 1'b1;
            addr_next  = '0;
        end else if (issue_reg) begin
            addr_next = addr_reg + SLOT_W'(1);
            if (addr_reg == LAST_SLOT) begin
                issue_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg  <= 1'b0;
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            issue_reg  <= issue_next;
            addr_reg   <= addr_next;
            rd_vld_reg <= issue_reg;
        end
    end

    assign diff     = now_ticks - rd_data_reg;
    assign evt.due  = rd_vld_reg && !diff[TICK_BITS-1];
    assign evt.done = rd_vld_reg && (rd_idx_reg == LAST_SLOT);
    assign evt.idx  = rd_idx_reg;

endmodule

// ===== hw/rtl/button_pulse_report_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_pulse_report_manager
// button mask, timed pulse presses and report pacing on millisecond ticks
// ----------------------------------------------------------------------------
// set, pulse and refused transactions do not stall; the next is taken at once
// a tick with host ready and pulses held stalls for one release time
//   memory read per button through the shared due compare, then the report
// with no pulses a ready tick goes to the report; unready ticks do not stall
// a report waits in the output register while further transactions are taken
// aresetn clears masks, tick count and pending flag; release times stay unset
module button_pulse_report_manager (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // new_buttons[31:0], button_index[36:32], press_ticks[67:37],
    // host_ready[68], zero pad
    input  logic [bprm_pkg::S_DATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  logic [bprm_pkg::KIND_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // report_buttons[31:0]
    output logic [bprm_pkg::M_DATA_W-1:0]   m_tdata
);
    import bprm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [BTN_W-1:0]     mask_reg, mask_next;
    logic [BTN_W-1:0]     pulse_reg, pulse_next;
    logic [TICK_BITS-1:0] now_reg, now_next;
    logic                 pend_reg, pend_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;

    logic [BTN_W-1:0]     req;
    logic [SLOT_W-1:0]    idx;
    logic [DUR_W-1:0]     dur;
    logic                 ready;
    logic                 accept;
    logic [BTN_W-1:0]     free_bits;
    logic [BTN_W-1:0]     idx_bit;
    logic                 wr_en;
    logic [TICK_BITS-1:0] wr_data;
    logic                 scan_start;
    scan_evt_t            evt;

    assign req   = s_tdata[BTN_W-1:0] & BTN_MASK;
    assign idx   = s_tdata[BTN_W +: SLOT_W];
    assign dur   = s_tdata[BTN_W+SLOT_W +: DUR_W];
    assign ready = s_tdata[BTN_W+SLOT_W+DUR_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign free_bits = ~pulse_reg & BTN_MASK;
    assign idx_bit   = BTN_W'(1) << idx;

    assign wr_en   = accept && (s_tuser == KIND_PULSE)
                     && ({1'b0, idx} < (SLOT_W + 1)'(NUM_BUTTONS));
    assign wr_data = now_reg + TICK_BITS'(dur);
    assign scan_start = accept && (s_tuser == KIND_TICK) && ready && (pulse_reg != '0);

    bprm_expire_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_idx    (idx),
        .wr_data   (wr_data),
        .start     (scan_start),
        .now_ticks (now_reg),
        .evt       (evt)
    );

    always_comb begin
        state_next   = state_reg;
        mask_next    = mask_reg;
        pulse_next   = pulse_reg;
        now_next     = now_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_tuser)
                        KIND_SET: begin
                            if ((mask_reg & free_bits) != (req & free_bits)) begin
                                mask_next = (mask_reg & pulse_reg) | (req & free_bits);
                                pend_next = 1'b1;
                            end
                        end
                        KIND_PULSE: begin
                            if (wr_en) begin
                                pulse_next = pulse_reg | idx_bit;
                                mask_next  = mask_reg | idx_bit;
                                pend_next  = 1'b1;
                            end
                        end
                        KIND_TICK: begin
                            now_next = now_reg + TICK_BITS'(1);
                            if (ready) begin
                                state_next = scan_start ? ST_SCAN : ST_EMIT;
                            end
                        end
                        KIND_REFUSE: begin
                            pend_next = 1'b1;
                        end
                        default: begin
                            pend_next = pend_reg;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (evt.due && pulse_reg[evt.idx]) begin
                    pulse_next[evt.idx] = 1'b0;
                    mask_next[evt.idx]  = 1'b0;
                    pend_next           = 1'b1;
                end
                if (evt.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!pend_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = mask_reg;
                    pend_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mask_reg    <= '0;
            pulse_reg   <= '0;
            now_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mask_reg    <= mask_next;
            pulse_reg   <= pulse_next;
            now_reg     <= now_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hw/rtl/bprm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprm_checker
// port level checks of the button pulse report manager, bound to the top
// ----------------------------------------------------------------------------
module bprm_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [bprm_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [bprm_pkg::KIND_W-1:0]     s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bprm_pkg::M_DATA_W-1:0]   m_tdata
);
    import bprm_pkg::*;

    localparam int READY_BIT = BTN_W + SLOT_W + DUR_W;

    // reset leaves no report and an open input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear output or reopen input");

    // stalled report holds
    a_report_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled report changed");

    // set, pulse and refused transactions never close the input
    a_quick_kinds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != KIND_TICK) |=> s_tready)
        else $error("non-tick transaction stalled input");

    // tick without host ready only advances time
    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_TICK) && !s_tdata[READY_BIT]
        |=> s_tready)
        else $error("not-ready tick stalled input");

    // tick with host ready closes the input for expiry, if pulses are held, and report
    a_ready_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_TICK) && s_tdata[READY_BIT]
        |=> !s_tready)
        else $error("ready tick skipped expiry");

endmodule

bind button_pulse_report_manager bprm_checker u_bprm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
